/* sv/rcvc_pkg.sv */
// ----------------------------------------------------------------------------
// rcvc_pkg: shared types and constants of the RC vehicle command controller
// Item and result layouts, command codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package rcvc_pkg;

    localparam int unsigned DutyW  = 8;
    localparam int unsigned TicksW = 16;
    localparam int unsigned OpW    = 4;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 16;

    localparam logic [DutyW-1:0]  CruiseDutyRst = 8'd151;
    localparam logic [DutyW-1:0]  SpeedStepRst  = 8'd26;
    localparam logic [DutyW-1:0]  HornOnDutyRst = 8'd114;
    localparam logic [TicksW-1:0] ObstLimitRst  = 16'd67;
    localparam logic [DutyW-1:0]  DutyMax       = 8'd255;
    localparam logic [DutyW-1:0]  HornSilent    = 8'd255;

    typedef enum logic [OpW-1:0] {
        OP_FWD     = 4'd0,
        OP_REV     = 4'd1,
        OP_BRAKE   = 4'd2,
        OP_LEFT    = 4'd3,
        OP_RIGHT   = 4'd4,
        OP_FASTER  = 4'd5,
        OP_SLOWER  = 4'd6,
        OP_LIGHTS  = 4'd7,
        OP_HAZARD  = 4'd8,
        OP_SIG_L   = 4'd9,
        OP_SIG_R   = 4'd10,
        OP_HORN    = 4'd11,
        OP_ECHO    = 4'd12
    } t_opcode;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_CRUISE_DUTY = 2'd0,
        CFG_SPEED_STEP  = 2'd1,
        CFG_HORN_ON     = 2'd2,
        CFG_OBST_LIMIT  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [OpW-1:0]    opcode;
        logic [TicksW-1:0] echo_ticks;
    } t_in_item;

    typedef struct packed {
        logic [DutyW-1:0] left_side_duty;
        logic [DutyW-1:0] right_side_duty;
        logic             reverse_drive;
        logic             headlight_on;
        logic             blink_left_enable;
        logic             blink_right_enable;
        logic [DutyW-1:0] horn_duty;
    } t_out_item;

    typedef struct packed {
        logic [DutyW-1:0]  cruise_duty;
        logic [DutyW-1:0]  speed_step;
        logic [DutyW-1:0]  horn_on_duty;
        logic [TicksW-1:0] obstacle_limit_ticks;
    } t_cfg;

endpackage

/* sv/rc_vehicle_command_controller_top.sv */
// ----------------------------------------------------------------------------
// rc_vehicle_command_controller_top: RC vehicle command controller
// Drive, lighting and horn control from decoded commands and echo times.
// ----------------------------------------------------------------------------
// Each accepted command or echo item yields exactly one result: both wheel
// duties, direction, headlight, blinker enables and buzzer duty, as they
// stand after that item. An item passes through an input register,
// combinational update logic and a result register. The input register
// loads at the accepting edge; the item moves on to the result register
// when that has room, and the result is offered from there until it
// transfers. A new item is taken every cycle while the result side keeps
// up, one item per clock. A stall on the result side backs up through the
// two registers to the input stall. Configuration registers take a write
// every cycle (ready is always high) and must only be written while no
// item is in flight.
module rc_vehicle_command_controller_top
    import rcvc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // item input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_item            i_in_data,
    // result output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_item           o_out_data,
    // configuration write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    t_cfg      cfg;
    t_out_item result;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      advance;

    // move the held item into the result register when that has room
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;

    rcvc_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    rcvc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // input register: load whenever it is empty or draining this cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_data;
        end
    end

    // result register: hold while stalled, drop valid once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule

/* sv/rcvc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// rcvc_cfg_regs: configuration register file
// Four write-only registers loaded from the configuration write channel.
// ----------------------------------------------------------------------------
module rcvc_cfg_regs
    import rcvc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_en,
    input  logic [CfgIdxW-1:0]  i_wr_index,
    input  logic [CfgDataW-1:0] i_wr_data,
    output t_cfg                o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (t_cfg_idx'(i_wr_index))
                CFG_CRUISE_DUTY: n_cfg.cruise_duty          = i_wr_data[DutyW-1:0];
                CFG_SPEED_STEP:  n_cfg.speed_step           = i_wr_data[DutyW-1:0];
                CFG_HORN_ON:     n_cfg.horn_on_duty         = i_wr_data[DutyW-1:0];
                CFG_OBST_LIMIT:  n_cfg.obstacle_limit_ticks = i_wr_data[TicksW-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cruise_duty          <= CruiseDutyRst;
            r_cfg.speed_step           <= SpeedStepRst;
            r_cfg.horn_on_duty         <= HornOnDutyRst;
            r_cfg.obstacle_limit_ticks <= ObstLimitRst;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* sv/rcvc_core.sv */
// ----------------------------------------------------------------------------
// rcvc_core: vehicle state and command update
// Holds drive, lighting and horn state; computes the post-update view.
// ----------------------------------------------------------------------------
module rcvc_core
    import rcvc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    typedef enum logic [1:0] {
        TURN_NONE  = 2'd0,
        TURN_LEFT  = 2'd1,
        TURN_RIGHT = 2'd2
    } t_turn;

    logic             r_moving, n_moving;
    logic             r_rev, n_rev;
    logic [DutyW-1:0] r_duty_a, n_duty_a;
    logic [DutyW-1:0] r_duty_b, n_duty_b;
    t_turn            r_turn, n_turn;
    logic [DutyW-1:0] r_saved, n_saved;
    logic             r_lights, n_lights;
    logic             r_hazard, n_hazard;
    logic             r_sig_l, n_sig_l;
    logic             r_sig_r, n_sig_r;
    logic             r_blink_l, n_blink_l;
    logic             r_blink_r, n_blink_r;
    logic [DutyW-1:0] r_buzz, n_buzz;

    logic [DutyW:0]   sum_a, sum_b;
    logic [DutyW-1:0] up_a, up_b, dn_a, dn_b;
    logic             echo_stop;

    assign sum_a = {1'b0, r_duty_a} + {1'b0, i_cfg.speed_step};
    assign sum_b = {1'b0, r_duty_b} + {1'b0, i_cfg.speed_step};
    assign up_a  = sum_a[DutyW] ? DutyMax : sum_a[DutyW-1:0];
    assign up_b  = sum_b[DutyW] ? DutyMax : sum_b[DutyW-1:0];
    assign dn_a  = (r_duty_a > i_cfg.speed_step) ? r_duty_a - i_cfg.speed_step : '0;
    assign dn_b  = (r_duty_b > i_cfg.speed_step) ? r_duty_b - i_cfg.speed_step : '0;
    assign echo_stop = (i_item.echo_ticks != '0)
                    && (i_item.echo_ticks <= i_cfg.obstacle_limit_ticks);

    always_comb begin
        n_moving  = r_moving;
        n_rev     = r_rev;
        n_duty_a  = r_duty_a;
        n_duty_b  = r_duty_b;
        n_turn    = r_turn;
        n_saved   = r_saved;
        n_lights  = r_lights;
        n_hazard  = r_hazard;
        n_sig_l   = r_sig_l;
        n_sig_r   = r_sig_r;
        n_blink_l = r_blink_l;
        n_blink_r = r_blink_r;
        n_buzz    = r_buzz;
        case (t_opcode'(i_item.opcode))
            OP_FWD, OP_REV: begin
                n_rev    = (t_opcode'(i_item.opcode) == OP_REV);
                n_duty_a = i_cfg.cruise_duty;
                n_duty_b = i_cfg.cruise_duty;
                n_moving = 1'b1;
            end
            OP_BRAKE: begin
                n_rev    = 1'b0;
                n_duty_a = '0;
                n_duty_b = '0;
                n_moving = 1'b0;
                n_turn   = TURN_NONE;
            end
            OP_LEFT: begin
                if (r_moving && r_turn == TURN_NONE) begin
                    n_saved  = r_duty_b;
                    n_duty_b = '0;
                    n_turn   = TURN_LEFT;
                end else if (r_moving && r_turn == TURN_LEFT) begin
                    n_duty_b = r_saved;
                    n_turn   = TURN_NONE;
                end
            end
            OP_RIGHT: begin
                if (r_moving && r_turn == TURN_NONE) begin
                    n_saved  = r_duty_a;
                    n_duty_a = '0;
                    n_turn   = TURN_RIGHT;
                end else if (r_moving && r_turn == TURN_RIGHT) begin
                    n_duty_a = r_saved;
                    n_turn   = TURN_NONE;
                end
            end
            OP_FASTER: begin
                if (r_moving && !(r_duty_a == DutyMax && r_duty_b == DutyMax)) begin
                    n_duty_a = up_a;
                    n_duty_b = up_b;
                end
            end
            OP_SLOWER: begin
                if (r_moving && !(r_duty_a == i_cfg.cruise_duty
                                  && r_duty_b == i_cfg.cruise_duty)) begin
                    n_duty_a = dn_a;
                    n_duty_b = dn_b;
                end
            end
            OP_LIGHTS: begin
                n_lights = !r_lights;
            end
            OP_HAZARD: begin
                n_hazard  = !r_hazard;
                n_sig_l   = !r_hazard;
                n_sig_r   = !r_hazard;
                n_blink_l = !r_hazard;
                n_blink_r = !r_hazard;
            end
            OP_SIG_L: begin
                if (!r_hazard && !r_sig_l) begin
                    n_blink_r = 1'b0;
                    n_blink_l = 1'b1;
                    n_sig_l   = 1'b1;
                end else if (!r_hazard) begin
                    n_blink_l = 1'b0;
                    n_sig_l   = 1'b0;
                end
            end
            OP_SIG_R: begin
                if (!r_hazard && !r_sig_r) begin
                    n_blink_l = 1'b0;
                    n_blink_r = 1'b1;
                    n_sig_r   = 1'b1;
                end else if (!r_hazard) begin
                    n_blink_r = 1'b0;
                    n_sig_r   = 1'b0;
                end
            end
            OP_HORN: begin
                n_buzz = (r_buzz == HornSilent) ? i_cfg.horn_on_duty : HornSilent;
            end
            OP_ECHO: begin
                // stop the motors but keep moving and any pending turn
                if (echo_stop) begin
                    n_rev    = 1'b0;
                    n_duty_a = '0;
                    n_duty_b = '0;
                end
            end
            default: begin
                n_moving = r_moving;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_moving  <= 1'b0;
            r_rev     <= 1'b0;
            r_duty_a  <= '0;
            r_duty_b  <= '0;
            r_turn    <= TURN_NONE;
            r_saved   <= '0;
            r_lights  <= 1'b0;
            r_hazard  <= 1'b0;
            r_sig_l   <= 1'b0;
            r_sig_r   <= 1'b0;
            r_blink_l <= 1'b0;
            r_blink_r <= 1'b0;
            r_buzz    <= HornSilent;
        end else if (i_step) begin
            r_moving  <= n_moving;
            r_rev     <= n_rev;
            r_duty_a  <= n_duty_a;
            r_duty_b  <= n_duty_b;
            r_turn    <= n_turn;
            r_saved   <= n_saved;
            r_lights  <= n_lights;
            r_hazard  <= n_hazard;
            r_sig_l   <= n_sig_l;
            r_sig_r   <= n_sig_r;
            r_blink_l <= n_blink_l;
            r_blink_r <= n_blink_r;
            r_buzz    <= n_buzz;
        end
    end

    assign o_result.left_side_duty     = n_duty_a;
    assign o_result.right_side_duty    = n_duty_b;
    assign o_result.reverse_drive      = n_rev;
    assign o_result.headlight_on       = n_lights;
    assign o_result.blink_left_enable  = n_blink_l;
    assign o_result.blink_right_enable = n_blink_r;
    assign o_result.horn_duty          = n_buzz;

endmodule
